[design/bnte_pkg.sv]
// bnte_pkg: shared types, register indexes and alphabet functions for the
// base-N text encoder. No dependencies; bnte_cfg_if, bnte_char_gen and base_n_text_encoder use it.

package bnte_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_MODE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAD_ENABLE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PAD_SYMBOL   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BREAK_ENABLE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_CHARS   = 3'd4;

  // Encoding modes; codes above base32hex behave as base16
  localparam logic [2:0] MODE_B64    = 3'd0;
  localparam logic [2:0] MODE_B64URL = 3'd1;
  localparam logic [2:0] MODE_B32    = 3'd2;
  localparam logic [2:0] MODE_B32HEX = 3'd3;

  localparam int unsigned ACC_BITS   = 12;
  localparam int unsigned LINE_BITS  = 16;
  localparam logic [7:0]  NEWLINE    = 8'h0A;
  localparam logic [7:0]  PAD_RESET  = 8'h3D;
  localparam logic [15:0] LINE_RESET = 16'd72;

  // Bit accumulator state carried from item to item
  typedef struct packed {
    logic [ACC_BITS-1:0] acc;
    logic [3:0]          cnt;
    logic [2:0]          gpos;
  } enc_state_t;

  // One step of the character generator
  typedef struct packed {
    logic [7:0] sym;
    logic       more;
    enc_state_t nxt;
  } gen_out_t;

  // Bits per symbol
  function automatic logic [3:0] sym_width(input logic [2:0] mode);
    logic [3:0] w;
    case (mode) inside
      MODE_B64, MODE_B64URL: w = 4'd6;
      MODE_B32, MODE_B32HEX: w = 4'd5;
      default:               w = 4'd4;
    endcase
    return w;
  endfunction

  function automatic logic [5:0] sym_mask(input logic [2:0] mode);
    logic [5:0] m;
    case (mode) inside
      MODE_B64, MODE_B64URL: m = 6'h3F;
      MODE_B32, MODE_B32HEX: m = 6'h1F;
      default:               m = 6'h0F;
    endcase
    return m;
  endfunction

  // Characters per group minus one; zero means no padding
  function automatic logic [2:0] group_mask(input logic [2:0] mode);
    logic [2:0] g;
    case (mode) inside
      MODE_B64, MODE_B64URL: g = 3'd3;
      MODE_B32, MODE_B32HEX: g = 3'd7;
      default:               g = 3'd0;
    endcase
    return g;
  endfunction

  // Alphabet lookup by offset arithmetic
  function automatic logic [7:0] sym_of(input logic [2:0] mode, input logic [5:0] idx);
    logic [7:0] x;
    logic [7:0] c;
    x = {2'b00, idx};
    case (mode) inside
      MODE_B64, MODE_B64URL: begin
        if (idx < 6'd26)      c = x + 8'h41;
        else if (idx < 6'd52) c = x + 8'h47;
        else if (idx < 6'd62) c = x - 8'h04;
        else if (idx == 6'd62) c = (mode == MODE_B64) ? 8'h2B : 8'h2D;
        else                  c = (mode == MODE_B64) ? 8'h2F : 8'h5F;
      end
      MODE_B32: begin
        if (idx < 6'd26) c = x + 8'h41;
        else             c = x + 8'h18;
      end
      default: begin
        if (idx < 6'd10) c = x + 8'h30;
        else             c = x + 8'h37;
      end
    endcase
    return c;
  endfunction

endpackage

[design/bnte_cfg_if.sv]
// bnte_cfg_if: configuration write channel (valid/ready, register index, data).
// Depends on bnte_pkg for the field widths.

interface bnte_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bnte_pkg::CFG_INDEX_W-1:0] index;
  logic [bnte_pkg::CFG_DATA_W-1:0]  wdata;

  modport source(output valid, index, wdata, input ready);
  modport sink(input valid, index, wdata, output ready);
endinterface

[design/bnte_in_if.sv]
// bnte_in_if: message byte channel (valid/ready, byte, last flag).
// No dependencies.

interface bnte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

[design/bnte_out_if.sv]
// bnte_out_if: encoded character channel (valid/ready, character, last flag).
// No dependencies.

interface bnte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source(output valid, out_char, last_char, input ready);
  modport sink(input valid, out_char, last_char, output ready);
endinterface

[design/bnte_char_gen.sv]
// bnte_char_gen: picks the next symbol (data, flush or pad) from the bit
// accumulator and returns the state after it. Depends on bnte_pkg.

module bnte_char_gen import bnte_pkg::*; (
  input  logic [2:0] code_mode,
  input  logic       pad_enable,
  input  logic [7:0] pad_symbol,
  input  logic       last_flag,
  input  enc_state_t cur,
  output gen_out_t   res
);

  logic [3:0] w;
  logic [3:0] cnt_rem;
  logic [5:0] mask;
  logic [5:0] idx;
  logic [2:0] gmask;
  logic       pad_on;

  always_comb begin
    w       = sym_width(code_mode);
    mask    = sym_mask(code_mode);
    gmask   = group_mask(code_mode);
    pad_on  = pad_enable && (gmask != 3'd0);
    cnt_rem = cur.cnt - w;
    idx     = '0;
    res     = '0;
    res.nxt = cur;

    if (cur.cnt >= w) begin
      // full symbol from the top of the held bits
      idx          = 6'(cur.acc >> cnt_rem) & mask;
      res.sym      = sym_of(code_mode, idx);
      res.nxt.cnt  = cnt_rem;
      res.nxt.gpos = cur.gpos + 3'd1;
    end else if (last_flag && (cur.cnt != 4'd0)) begin
      // flush the partial symbol, left-aligned
      idx          = 6'(cur.acc << (w - cur.cnt)) & mask;
      res.sym      = sym_of(code_mode, idx);
      res.nxt.cnt  = 4'd0;
      res.nxt.gpos = cur.gpos + 3'd1;
    end else begin
      // pad up to a full group
      res.sym      = pad_symbol;
      res.nxt.gpos = cur.gpos + 3'd1;
    end

    res.more = (res.nxt.cnt >= w) ||
               (last_flag && ((res.nxt.cnt != 4'd0) ||
                              (pad_on && ((res.nxt.gpos & gmask) != 3'd0))));
  end

endmodule

[design/base_n_text_encoder.sv]
// base_n_text_encoder: base64/base64url/base32/base32hex/base16 text encoder.
// A byte is loaded into the bit accumulator, and the generator then writes its first
// character into the output register when the output is free, newlines aside.
// One character per cycle while the output is not stalled; a byte causes 1 or 2
// characters, plus newlines, plus flush and pads, and holds the generator until the last.
// Reset (synchronous, rst high) restores the register defaults and empties the encoder.

module base_n_text_encoder import bnte_pkg::*; #(
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  bnte_cfg_if.sink     cfg,
  bnte_in_if.sink      data_in,
  bnte_out_if.source   char_out
);

  localparam int unsigned CMP_BITS = (COLUMN_BITS > LINE_BITS) ? COLUMN_BITS : LINE_BITS;

  // Configuration registers
  logic [2:0]           code_mode;
  logic                 pad_enable;
  logic [7:0]           pad_symbol;
  logic                 break_enable;
  logic [LINE_BITS-1:0] line_chars;

  // Encoder state
  enc_state_t             enc, enc_next;
  logic                   last_flag, last_flag_next;
  logic                   busy, busy_next;
  logic [COLUMN_BITS-1:0] column, column_next;

  // Output register
  logic       out_valid, out_valid_next;
  logic [7:0] out_char, out_char_next;
  logic       out_last, out_last_next;

  gen_out_t gen;
  logic     advance;
  logic     nl_due;
  logic     emit_sym;
  logic     finishing;
  logic     accept;
  logic     cfg_write;
  logic [4:0] cnt_sum;

  bnte_char_gen u_char_gen (
    .code_mode  (code_mode),
    .pad_enable (pad_enable),
    .pad_symbol (pad_symbol),
    .last_flag  (last_flag),
    .cur        (enc),
    .res        (gen)
  );

  // Handshakes
  assign cfg.ready      = 1'b1;
  assign cfg_write      = cfg.valid && cfg.ready;
  assign advance        = !out_valid || char_out.ready;
  assign nl_due         = break_enable && (line_chars != '0) &&
                          (CMP_BITS'(column) >= CMP_BITS'(line_chars));
  assign emit_sym       = busy && advance && !nl_due;
  assign finishing      = emit_sym && !gen.more;
  assign data_in.ready  = !busy || finishing;
  assign accept         = data_in.valid && data_in.ready;

  assign char_out.valid     = out_valid;
  assign char_out.out_char  = out_char;
  assign char_out.last_char = out_last;

  // Next state: newline or symbol, then load of the next byte, then a mode-change clear
  always_comb begin
    enc_next       = enc;
    last_flag_next = last_flag;
    busy_next      = busy;
    column_next    = column;
    out_valid_next = out_valid;
    out_char_next  = out_char;
    out_last_next  = out_last;
    cnt_sum        = '0;

    if (advance) begin
      out_valid_next = busy;
    end

    if (busy && advance && nl_due) begin
      out_char_next = NEWLINE;
      out_last_next = 1'b0;
      column_next   = '0;
    end

    if (emit_sym) begin
      out_char_next = gen.sym;
      out_last_next = last_flag && !gen.more;
      enc_next      = gen.nxt;
      column_next   = (column == '1) ? column : column + 1'b1;
      if (!gen.more) begin
        busy_next = 1'b0;
        if (last_flag) begin
          // end of message: start the next one clean
          enc_next    = '0;
          column_next = '0;
        end
      end
    end

    if (accept) begin
      cnt_sum            = {1'b0, enc_next.cnt} + 5'd8;
      enc_next.acc       = {enc_next.acc[ACC_BITS-9:0], data_in.data_byte};
      enc_next.cnt       = (cnt_sum > 5'd12) ? 4'd12 : cnt_sum[3:0];
      busy_next          = 1'b1;
      last_flag_next     = data_in.last_byte;
    end

    // a mode change drops pending bits
    if (cfg_write && (cfg.index == REG_CODE_MODE)) begin
      enc_next = '0;
    end
  end

  // Hold encoder state and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      enc       <= '0;
      busy      <= 1'b0;
      last_flag <= 1'b0;
      column    <= '0;
      out_valid <= 1'b0;
    end else begin
      enc       <= enc_next;
      busy      <= busy_next;
      last_flag <= last_flag_next;
      column    <= column_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      code_mode    <= MODE_B64;
      pad_enable   <= 1'b1;
      pad_symbol   <= PAD_RESET;
      break_enable <= 1'b0;
      line_chars   <= LINE_RESET;
    end else if (cfg_write) begin
      unique case (cfg.index)
        REG_CODE_MODE:    code_mode    <= cfg.wdata[2:0];
        REG_PAD_ENABLE:   pad_enable   <= cfg.wdata[0];
        REG_PAD_SYMBOL:   pad_symbol   <= cfg.wdata[7:0];
        REG_BREAK_ENABLE: break_enable <= cfg.wdata[0];
        REG_LINE_CHARS:   line_chars   <= cfg.wdata[LINE_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

[design/bnte_checker.sv]
// bnte_checker: port-level assertions for base_n_text_encoder, with the bind
// that attaches it. Depends on the top level's interface ports.

module bnte_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled character changed");

  // Every byte causes a character, present on the output after its transfer
  a_byte_emits: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no character after byte transfer");

endmodule

bind base_n_text_encoder bnte_checker u_bnte_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (data_in.valid),
  .in_ready  (data_in.ready),
  .out_valid (char_out.valid),
  .out_ready (char_out.ready),
  .out_char  (char_out.out_char),
  .out_last  (char_out.last_char)
);
